/* rtl/cssa_pkg.sv */
// Shared types and constants for the call-site statistics accumulator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cssa_pkg;

   localparam int SUM_W = 64;
   localparam int CNT_W = 32;
   localparam int ADDR_W = 48;
   localparam int IDX_W_IN = 16;
   localparam int KIND_W = 4;
   localparam int FLAGS_W = 3;
   localparam int STATUS_W = 2;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_NEW = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MERGED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

   localparam int FLAG_RECURSIVE = 0;
   localparam int FLAG_RECORD = 1;
   localparam int FLAG_TOP = 2;

   typedef struct packed {
      logic              valid;
      logic              recursive;
      logic [KIND_W-1:0] kind;
      logic [SUM_W-1:0]  work;
      logic [SUM_W-1:0]  span;
      logic [SUM_W-1:0]  top_work;
      logic [SUM_W-1:0]  top_span;
      logic [SUM_W-1:0]  local_work;
      logic [SUM_W-1:0]  local_span;
      logic [CNT_W-1:0]  record_cnt;
      logic [CNT_W-1:0]  top_cnt;
      logic [CNT_W-1:0]  local_cnt;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic capture;
      logic sweep_step;
      logic commit;
      logic done_clear;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic sweep_last;
      logic out_free;
   } stat_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic d);
      logic [CNT_W-1:0] r;
      r = c;
      if (d && (c != '1)) begin
         r = c + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/cssa_ram.sv */
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cssa_ctrl.sv */
// Sequencer for the call-site statistics accumulator.
// Depends on cssa_pkg; drives commands into cssa_dpath.
`timescale 1ns / 1ps

module cssa_ctrl
   import cssa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_INIT     = 5'b00001,
      ST_IDLE     = 5'b00010,
      ST_LOOK     = 5'b00100,
      ST_SWEEP    = 5'b01000,
      ST_CLR_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (stat.is_clear) begin
               state_in = ST_SWEEP;
            end else if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_CLR_DONE;
            end
         end
         ST_CLR_DONE: begin
            if (stat.out_free) begin
               cmd.done_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/cssa_dpath.sv */
// Datapath: word capture, entry memory, merge arithmetic and result register.
// Depends on cssa_pkg and cssa_ram; commanded by cssa_ctrl.
`timescale 1ns / 1ps

module cssa_dpath
   import cssa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                req_opcode,
   input  logic [IDX_W_IN-1:0] req_site_index,
   input  logic [ADDR_W-1:0]   req_site_address,
   input  logic [FLAGS_W-1:0]  req_instance_flags,
   input  logic [KIND_W-1:0]   req_function_kind,
   input  logic [SUM_W-1:0]    req_work,
   input  logic [SUM_W-1:0]    req_span,
   input  logic [SUM_W-1:0]    req_local_work,
   input  logic [SUM_W-1:0]    req_local_span,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_recursive_seen,
   output logic [KIND_W-1:0]   rsp_function_type_out,
   output logic [SUM_W-1:0]    rsp_work_total,
   output logic [SUM_W-1:0]    rsp_span_total,
   output logic [CNT_W-1:0]    rsp_record_count,
   output logic [SUM_W-1:0]    rsp_top_work_total,
   output logic [SUM_W-1:0]    rsp_top_span_total,
   output logic [CNT_W-1:0]    rsp_top_count,
   output logic [SUM_W-1:0]    rsp_local_work_total,
   output logic [SUM_W-1:0]    rsp_local_span_total,
   output logic [CNT_W-1:0]    rsp_local_count
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic                op_ff;
   logic [IDX_W_IN-1:0] idx_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [FLAGS_W-1:0]  flags_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [SUM_W-1:0]    work_ff, span_ff, lwork_ff, lspan_ff;

   logic [IDX_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                sweep_last;

   logic [ENTRY_W-1:0]  rd_word;
   entry_type           cur;
   entry_type           upd;
   logic                reject;
   logic                is_rec, is_record, is_top;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   entry_type           out_ff;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         idx_ff   <= req_site_index;
         addr_ff  <= req_site_address;
         flags_ff <= req_instance_flags;
         kind_ff  <= req_function_kind;
         work_ff  <= req_work;
         span_ff  <= req_span;
         lwork_ff <= req_local_work;
         lspan_ff <= req_local_span;
      end
   end

   assign sweep_last = (sweep_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep_step) begin
         sweep_cnt_in = sweep_last ? '0 : sweep_cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   cssa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.capture),
      .rd_addr(req_site_index[IDX_W-1:0]),
      .rd_data(rd_word)
   );

   assign cur       = entry_type'(rd_word);
   assign is_rec    = flags_ff[FLAG_RECURSIVE];
   assign is_record = flags_ff[FLAG_RECORD];
   assign is_top    = flags_ff[FLAG_TOP];
   assign reject    = (32'(idx_ff) >= 32'(TABLE_ENTRIES)) || (addr_ff == '0);

   always_comb begin
      upd = '0;
      upd.valid = 1'b1;
      if (!cur.valid) begin
         upd.recursive  = is_rec;
         upd.kind       = kind_ff;
         upd.work       = work_ff;
         upd.span       = span_ff;
         upd.top_work   = is_top ? work_ff : '0;
         upd.top_span   = is_top ? span_ff : '0;
         upd.local_work = lwork_ff;
         upd.local_span = lspan_ff;
         upd.record_cnt = CNT_W'(is_record);
         upd.top_cnt    = CNT_W'(is_top);
         upd.local_cnt  = CNT_W'(1);
      end else begin
         upd.recursive  = cur.recursive | is_rec;
         upd.kind       = cur.kind;
         upd.work       = cur.work + work_ff;
         upd.span       = cur.span + span_ff;
         upd.top_work   = is_top ? cur.top_work + work_ff : cur.top_work;
         upd.top_span   = is_top ? cur.top_span + span_ff : cur.top_span;
         upd.local_work = cur.local_work + lwork_ff;
         upd.local_span = cur.local_span + lspan_ff;
         upd.record_cnt = sat_inc(cur.record_cnt, is_record);
         upd.top_cnt    = sat_inc(cur.top_cnt, is_top);
         upd.local_cnt  = sat_inc(cur.local_cnt, 1'b1);
      end
   end

   assign ram_wr_en   = cmd.sweep_step | (cmd.commit & ~reject);
   assign ram_wr_addr = cmd.sweep_step ? sweep_cnt_ff : idx_ff[IDX_W-1:0];
   assign ram_wr_data = cmd.sweep_step ? '0 : ENTRY_W'(upd);

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit || cmd.done_clear) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.done_clear) begin
         status_ff <= STATUS_CLEARED;
         out_ff    <= '0;
      end else if (cmd.commit) begin
         if (reject) begin
            status_ff <= STATUS_REJECT;
            out_ff    <= '0;
         end else begin
            status_ff <= cur.valid ? STATUS_MERGED : STATUS_NEW;
            out_ff    <= upd;
         end
      end
   end

   assign stat.is_clear   = (op_ff == OP_CLEAR);
   assign stat.sweep_last = sweep_last;
   assign stat.out_free   = out_free;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_recursive_seen    = out_ff.recursive;
   assign rsp_function_type_out = out_ff.kind;
   assign rsp_work_total        = out_ff.work;
   assign rsp_span_total        = out_ff.span;
   assign rsp_record_count      = out_ff.record_cnt;
   assign rsp_top_work_total    = out_ff.top_work;
   assign rsp_top_span_total    = out_ff.top_span;
   assign rsp_top_count         = out_ff.top_cnt;
   assign rsp_local_work_total  = out_ff.local_work;
   assign rsp_local_span_total  = out_ff.local_span;
   assign rsp_local_count       = out_ff.local_cnt;

endmodule

/* rtl/call_site_stats_accumulator.sv */
// Call-site profiling statistics table, one entry per call-site index. An add word
// reads its entry when it is taken; the entry is then merged and written back through the
// memory's single write port once the result register is free. A clear word, and the pass
// after reset, sweep the entry memory one entry per cycle with req_stall high.
// The result register lets the next word be taken while a result waits on rsp_stall.
// Depends on cssa_pkg, cssa_ctrl, cssa_dpath and cssa_ram.
`timescale 1ns / 1ps

module call_site_stats_accumulator
   import cssa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [IDX_W_IN-1:0] req_site_index,
   input  logic [ADDR_W-1:0]   req_site_address,
   input  logic [FLAGS_W-1:0]  req_instance_flags,
   input  logic [KIND_W-1:0]   req_function_kind,
   input  logic [SUM_W-1:0]    req_work,
   input  logic [SUM_W-1:0]    req_span,
   input  logic [SUM_W-1:0]    req_local_work,
   input  logic [SUM_W-1:0]    req_local_span,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_recursive_seen,
   output logic [KIND_W-1:0]   rsp_function_type_out,
   output logic [SUM_W-1:0]    rsp_work_total,
   output logic [SUM_W-1:0]    rsp_span_total,
   output logic [CNT_W-1:0]    rsp_record_count,
   output logic [SUM_W-1:0]    rsp_top_work_total,
   output logic [SUM_W-1:0]    rsp_top_span_total,
   output logic [CNT_W-1:0]    rsp_top_count,
   output logic [SUM_W-1:0]    rsp_local_work_total,
   output logic [SUM_W-1:0]    rsp_local_span_total,
   output logic [CNT_W-1:0]    rsp_local_count
);

   cmd_type  cmd;
   stat_type stat;

   cssa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   cssa_dpath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_opcode           (req_opcode),
      .req_site_index       (req_site_index),
      .req_site_address     (req_site_address),
      .req_instance_flags   (req_instance_flags),
      .req_function_kind    (req_function_kind),
      .req_work             (req_work),
      .req_span             (req_span),
      .req_local_work       (req_local_work),
      .req_local_span       (req_local_span),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_recursive_seen   (rsp_recursive_seen),
      .rsp_function_type_out(rsp_function_type_out),
      .rsp_work_total       (rsp_work_total),
      .rsp_span_total       (rsp_span_total),
      .rsp_record_count     (rsp_record_count),
      .rsp_top_work_total   (rsp_top_work_total),
      .rsp_top_span_total   (rsp_top_span_total),
      .rsp_top_count        (rsp_top_count),
      .rsp_local_work_total (rsp_local_work_total),
      .rsp_local_span_total (rsp_local_span_total),
      .rsp_local_count      (rsp_local_count)
   );

endmodule

/* tb/sv/call_site_stats_accumulator_tb.sv */
// Self-checking testbench for call_site_stats_accumulator: directed and random sample words,
// a predictor of the call-site table, and a scoreboard on the result channel.
// Depends on cssa_pkg and the call_site_stats_accumulator RTL.
`timescale 1ns / 1ps

module call_site_stats_accumulator_tb;
   import cssa_pkg::*;

   localparam int N_SITES = 1024;
   localparam int SITE_W = $clog2(N_SITES);
   localparam int RANDOM_WORDS = 1600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic                opcode;
      logic [IDX_W_IN-1:0] site_index;
      logic [ADDR_W-1:0]   site_address;
      logic [FLAGS_W-1:0]  instance_flags;
      logic [KIND_W-1:0]   function_kind;
      logic [SUM_W-1:0]    work;
      logic [SUM_W-1:0]    span;
      logic [SUM_W-1:0]    local_work;
      logic [SUM_W-1:0]    local_span;
   } sample_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                recursive_seen;
      logic [KIND_W-1:0]   function_type;
      logic [SUM_W-1:0]    work_total;
      logic [SUM_W-1:0]    span_total;
      logic [CNT_W-1:0]    record_count;
      logic [SUM_W-1:0]    top_work_total;
      logic [SUM_W-1:0]    top_span_total;
      logic [CNT_W-1:0]    top_hits;
      logic [SUM_W-1:0]    local_work_total;
      logic [SUM_W-1:0]    local_span_total;
      logic [CNT_W-1:0]    merge_count;
   } site_stats_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_ADD;
   logic [IDX_W_IN-1:0] req_site_index = '0;
   logic [ADDR_W-1:0]   req_site_address = '0;
   logic [FLAGS_W-1:0]  req_instance_flags = '0;
   logic [KIND_W-1:0]   req_function_kind = '0;
   logic [SUM_W-1:0]    req_work = '0;
   logic [SUM_W-1:0]    req_span = '0;
   logic [SUM_W-1:0]    req_local_work = '0;
   logic [SUM_W-1:0]    req_local_span = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_recursive_seen;
   logic [KIND_W-1:0]   rsp_function_type_out;
   logic [SUM_W-1:0]    rsp_work_total;
   logic [SUM_W-1:0]    rsp_span_total;
   logic [CNT_W-1:0]    rsp_record_count;
   logic [SUM_W-1:0]    rsp_top_work_total;
   logic [SUM_W-1:0]    rsp_top_span_total;
   logic [CNT_W-1:0]    rsp_top_count;
   logic [SUM_W-1:0]    rsp_local_work_total;
   logic [SUM_W-1:0]    rsp_local_span_total;
   logic [CNT_W-1:0]    rsp_local_count;

   sample_word_type pending_words[$];
   site_stats_type  expected_stats[$];
   sample_word_type cur_word;
   logic         req_taken = 1'b0;
   int           words_accepted = 0;
   int           idle_cycles = 0;
   int           mismatches = 0;

   // predictor copy of the table
   logic         site_live [N_SITES];
   site_stats_type site_stats [N_SITES];
   logic [ADDR_W-1:0] home_address [N_SITES];

   call_site_stats_accumulator #(
      .TABLE_ENTRIES(N_SITES)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_site_index       (req_site_index),
      .req_site_address     (req_site_address),
      .req_instance_flags   (req_instance_flags),
      .req_function_kind    (req_function_kind),
      .req_work             (req_work),
      .req_span             (req_span),
      .req_local_work       (req_local_work),
      .req_local_span       (req_local_span),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_recursive_seen   (rsp_recursive_seen),
      .rsp_function_type_out(rsp_function_type_out),
      .rsp_work_total       (rsp_work_total),
      .rsp_span_total       (rsp_span_total),
      .rsp_record_count     (rsp_record_count),
      .rsp_top_work_total   (rsp_top_work_total),
      .rsp_top_span_total   (rsp_top_span_total),
      .rsp_top_count        (rsp_top_count),
      .rsp_local_work_total (rsp_local_work_total),
      .rsp_local_span_total (rsp_local_span_total),
      .rsp_local_count      (rsp_local_count)
   );

   always #1 clock = ~clock;

   function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c, input logic hit);
      return (hit && c != '1) ? c + CNT_W'(1) : c;
   endfunction

   function automatic site_stats_type accumulate_sample(input sample_word_type w);
      site_stats_type    r;
      site_stats_type    e;
      logic              top;
      logic [SITE_W-1:0] slot;
      r = '0;
      if (w.opcode == OP_CLEAR) begin
         foreach (site_live[i]) site_live[i] = 1'b0;
         r.status = STATUS_CLEARED;
         return r;
      end
      if (w.site_index >= N_SITES || w.site_address == '0) begin
         r.status = STATUS_REJECT;
         return r;
      end
      slot = w.site_index[SITE_W-1:0];
      top = w.instance_flags[FLAG_TOP];
      if (!site_live[slot]) begin
         e = '0;
         e.status = STATUS_NEW;
         e.recursive_seen = w.instance_flags[FLAG_RECURSIVE];
         e.function_type = w.function_kind;
         e.work_total = w.work;
         e.span_total = w.span;
         e.record_count = CNT_W'(w.instance_flags[FLAG_RECORD]);
         e.top_work_total = top ? w.work : '0;
         e.top_span_total = top ? w.span : '0;
         e.top_hits = CNT_W'(top);
         e.local_work_total = w.local_work;
         e.local_span_total = w.local_span;
         e.merge_count = CNT_W'(1);
         site_live[slot] = 1'b1;
      end else begin
         e = site_stats[slot];
         e.status = STATUS_MERGED;
         e.recursive_seen = e.recursive_seen | w.instance_flags[FLAG_RECURSIVE];
         e.work_total = e.work_total + w.work;
         e.span_total = e.span_total + w.span;
         if (top) begin
            e.top_work_total = e.top_work_total + w.work;
            e.top_span_total = e.top_span_total + w.span;
         end
         e.local_work_total = e.local_work_total + w.local_work;
         e.local_span_total = e.local_span_total + w.local_span;
         e.record_count = bump_count(e.record_count, w.instance_flags[FLAG_RECORD]);
         e.top_hits = bump_count(e.top_hits, top);
         e.merge_count = bump_count(e.merge_count, 1'b1);
      end
      site_stats[slot] = e;
      return e;
   endfunction

   function automatic sample_word_type add_word(input logic [IDX_W_IN-1:0] idx,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [FLAGS_W-1:0] flags,
                                                input logic [KIND_W-1:0] kind,
                                                input logic [SUM_W-1:0] w, s, lw, ls);
      sample_word_type x;
      x.opcode = OP_ADD;
      x.site_index = idx;
      x.site_address = addr;
      x.instance_flags = flags;
      x.function_kind = kind;
      x.work = w;
      x.span = s;
      x.local_work = lw;
      x.local_span = ls;
      return x;
   endfunction

   function automatic logic [SUM_W-1:0] sum_of(input int unsigned n);
      return SUM_W'(n);
   endfunction

   function automatic logic [SUM_W-1:0] rand_sum();
      logic [SUM_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: v = v >> $urandom_range(63);
         1: v = ~(v >> $urandom_range(63));
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_address();
      logic [ADDR_W-1:0] a;
      a = ADDR_W'({$urandom, $urandom});
      if (a == '0) a = ADDR_W'(1);
      return a;
   endfunction

   // clear words carry random payload, which the block must ignore
   function automatic sample_word_type clear_word();
      sample_word_type x;
      x = add_word(IDX_W_IN'($urandom), rand_address(), FLAGS_W'($urandom),
                   KIND_W'($urandom), rand_sum(), rand_sum(), rand_sum(), rand_sum());
      x.opcode = OP_CLEAR;
      return x;
   endfunction

   function automatic sample_word_type random_word();
      int                  pick;
      logic [IDX_W_IN-1:0] idx;
      logic [ADDR_W-1:0]   addr;
      pick = $urandom_range(99);
      if (pick < 2) return clear_word();
      if (pick < 5) begin
         idx = IDX_W_IN'($urandom_range(65535, N_SITES));
         addr = rand_address();
      end else if (pick < 8) begin
         idx = IDX_W_IN'($urandom);
         addr = '0;
      end else begin
         case ($urandom_range(9))
            0: idx = $urandom_range(1) ? IDX_W_IN'(0) : IDX_W_IN'(N_SITES - 1);
            1, 2, 3: idx = IDX_W_IN'($urandom_range(N_SITES - 1));
            default: idx = IDX_W_IN'($urandom_range(15));
         endcase
         addr = ($urandom_range(6) == 0) ? rand_address() : home_address[idx[SITE_W-1:0]];
      end
      return add_word(idx, addr, FLAGS_W'($urandom), KIND_W'($urandom),
                      rand_sum(), rand_sum(), rand_sum(), rand_sum());
   endfunction

   task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                              input logic [SUM_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin : stimulus
      localparam logic [SUM_W-1:0] TOP_BIT = {1'b1, {(SUM_W-1){1'b0}}};
      foreach (site_live[i]) site_live[i] = 1'b0;
      foreach (home_address[i]) home_address[i] = rand_address();

      pending_words.push_back(add_word(IDX_W_IN'(0), '1, 3'b111, 4'hF, '1, '1, '1, '1));
      // different address on a live entry: merge, keep type, wrap sums to zero
      pending_words.push_back(add_word(IDX_W_IN'(0), 48'h1234_5678_9ABC, 3'b000, 4'h0,
                                       sum_of(1), sum_of(1), sum_of(1), sum_of(1)));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES - 1), 48'h1, 3'b000, 4'h0,
                                       '0, '0, '0, '0));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES - 1), 48'h1, 3'b001, 4'h5,
                                       sum_of(2), sum_of(3), sum_of(4), sum_of(5)));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES - 1), 48'h1, 3'b010, 4'h6,
                                       sum_of(6), sum_of(7), sum_of(8), sum_of(9)));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES - 1), 48'h1, 3'b100, 4'h7,
                                       sum_of(10), sum_of(11), sum_of(12), sum_of(13)));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES), 48'h1, 3'b111, 4'hF,
                                       sum_of(1), sum_of(1), sum_of(1), sum_of(1)));
      pending_words.push_back(add_word('1, '1, 3'b111, 4'hF, '1, '1, '1, '1));
      pending_words.push_back(add_word(IDX_W_IN'(5), '0, 3'b111, 4'hF,
                                       sum_of(1), sum_of(1), sum_of(1), sum_of(1)));
      pending_words.push_back(add_word(IDX_W_IN'(5), 48'h8000_0000_0000, 3'b110, 4'hA,
                                       TOP_BIT, TOP_BIT, TOP_BIT, TOP_BIT));
      pending_words.push_back(add_word(IDX_W_IN'(5), 48'h8000_0000_0000, 3'b110, 4'h1,
                                       TOP_BIT, TOP_BIT, TOP_BIT, TOP_BIT));
      pending_words.push_back(clear_word());
      pending_words.push_back(add_word(IDX_W_IN'(0), '1, 3'b000, 4'h3,
                                       sum_of(5), sum_of(6), sum_of(7), sum_of(8)));
      pending_words.push_back(add_word(IDX_W_IN'(N_SITES - 1), 48'h2, 3'b101, 4'h9,
                                       '1, '0, '1, '0));
      pending_words.push_back(add_word(IDX_W_IN'(5), 48'h3, 3'b011, 4'hC, '0, '1, '0, '1));
      pending_words.push_back(clear_word());
      pending_words.push_back(clear_word());
      pending_words.push_back(add_word(IDX_W_IN'(1), 48'hABC, 3'b101, 4'h9, '1, '1, '1, '1));
      pending_words.push_back(add_word(IDX_W_IN'(1), 48'hABC, 3'b101, 4'h2, '1, '1, '1, '1));

      for (int n = 0; n < RANDOM_WORDS; n++) pending_words.push_back(random_word());

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_stats.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(negedge clock) begin : word_driver
      int send_idle;
      int stall_rate;
      case ((words_accepted / 100) % 4)
         0: begin
            send_idle = 0;
            stall_rate = 0;
         end
         1: begin
            send_idle = 56;
            stall_rate = 0;
         end
         2: begin
            send_idle = 0;
            stall_rate = 56;
         end
         default: begin
            send_idle = 37;
            stall_rate = 37;
         end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // hold the word until it is taken
         if (!req_valid || req_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
               cur_word = pending_words.pop_front();
               req_opcode <= cur_word.opcode;
               req_site_index <= cur_word.site_index;
               req_site_address <= cur_word.site_address;
               req_instance_flags <= cur_word.instance_flags;
               req_function_kind <= cur_word.function_kind;
               req_work <= cur_word.work;
               req_span <= cur_word.span;
               req_local_work <= cur_word.local_work;
               req_local_span <= cur_word.local_span;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_rate);
      end
   end

   always @(posedge clock) begin : result_monitor
      site_stats_type want;
      logic        progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (expected_stats.size() == 0) begin
               $error("result word with none expected, status %0d", rsp_status);
               mismatches++;
            end else begin
               want = expected_stats.pop_front();
               check_field("rsp_status", SUM_W'(want.status), SUM_W'(rsp_status));
               check_field("rsp_recursive_seen", SUM_W'(want.recursive_seen),
                           SUM_W'(rsp_recursive_seen));
               check_field("rsp_function_type_out", SUM_W'(want.function_type),
                           SUM_W'(rsp_function_type_out));
               check_field("rsp_work_total", want.work_total, rsp_work_total);
               check_field("rsp_span_total", want.span_total, rsp_span_total);
               check_field("rsp_record_count", SUM_W'(want.record_count),
                           SUM_W'(rsp_record_count));
               check_field("rsp_top_work_total", want.top_work_total, rsp_top_work_total);
               check_field("rsp_top_span_total", want.top_span_total, rsp_top_span_total);
               check_field("rsp_top_count", SUM_W'(want.top_hits), SUM_W'(rsp_top_count));
               check_field("rsp_local_work_total", want.local_work_total,
                           rsp_local_work_total);
               check_field("rsp_local_span_total", want.local_span_total,
                           rsp_local_span_total);
               check_field("rsp_local_count", SUM_W'(want.merge_count),
                           SUM_W'(rsp_local_count));
            end
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            expected_stats.push_back(accumulate_sample(cur_word));
            words_accepted++;
         end
         req_taken <= req_valid && !req_stall;
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule

/* filelist.f */
rtl/cssa_pkg.sv
rtl/cssa_ram.sv
rtl/cssa_ctrl.sv
rtl/cssa_dpath.sv
rtl/call_site_stats_accumulator.sv
tb/sv/call_site_stats_accumulator_tb.sv
